[hdl/crc16_frame_receiver_macros.svh]
// assertion macros for the crc16 frame receiver
// used by modules that check their own control logic; no other dependencies
`ifndef CRC16_FRAME_RECEIVER_MACROS_SVH
`define CRC16_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled in reset
`define CRCFR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CRCFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/crcfr_pkg.sv]
// shared types, status codes and the crc-16/modbus byte update
// no dependencies
package crcfr_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_CRC = 2'd2;
    localparam logic [1:0] ST_BAD_END = 2'd3;

    localparam logic [7:0] LEN_OVERHEAD = 8'd3;
    localparam logic [7:0] LEN_MIN      = 8'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] START_RST = 8'hAA;
    localparam logic [7:0] END_RST   = 8'h55;

    // frame byte count field, holds up to 63 payload bytes
    localparam int unsigned CMD_CNT_W = 6;

    typedef struct packed {
        logic [1:0]           status;
        logic [CMD_CNT_W-1:0] count;
    } t_cmd;

    // back-pressure view of the queue and drain side, seen by the front
    typedef struct packed {
        logic full;
        logic empty;
        logic busy;
    } t_flow;

    // reflected crc-16, one byte, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hdl/crcfr_if.sv]
// stream interfaces: received bytes in, frame results out
// no dependencies
interface crcfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output status, output data_byte, output last, input ready);
    modport sink   (input valid, input status, input data_byte, input last, output ready);
endinterface

[hdl/crcfr_front.sv]
// frame parser: start hunt, length check, payload capture, crc check, end check
// depends on crcfr_pkg and crcfr_byte_if
module crcfr_front #(
    parameter int unsigned MAX_PAYLOAD = 20,
    parameter int unsigned ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_start_byte,
    input  logic [7:0]         i_end_byte,
    crcfr_byte_if.sink         i_rx,
    input  crcfr_pkg::t_flow   i_flow,
    output logic               o_push,
    output crcfr_pkg::t_cmd    o_cmd,
    output logic               o_wr_en,
    output logic [ADDR_W-1:0]  o_wr_addr,
    output logic [7:0]         o_wr_data
);
    import crcfr_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0]  LEN_MAX = 8'(MAX_PAYLOAD) + LEN_OVERHEAD;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_CRCH    = 3'd3;
    localparam logic [2:0] PH_CRCL    = 3'd4;
    localparam logic [2:0] PH_END     = 3'd5;

    logic [2:0]       r_phase,  n_phase;
    logic [CNT_W-1:0] r_plen,   n_plen;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [15:0]      r_crc,    n_crc;
    logic [7:0]       r_crc_hi, n_crc_hi;
    logic             accept;
    logic [7:0]       b;

    // payload bytes wait while an earlier frame still drains from the buffer
    assign i_rx.ready = !i_flow.full &&
                        !((r_phase == PH_PAYLOAD) && (!i_flow.empty || i_flow.busy));
    assign accept = i_rx.valid && i_rx.ready;
    assign b      = i_rx.rx_byte;

    assign o_wr_addr = r_count[ADDR_W-1:0];
    assign o_wr_data = b;

    always_comb begin
        n_phase  = r_phase;
        n_plen   = r_plen;
        n_count  = r_count;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        o_push   = 1'b0;
        o_cmd    = '0;
        o_wr_en  = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (b == i_start_byte) begin
                        n_phase = PH_LEN;
                        n_count = '0;
                        n_crc   = CRC_INIT;
                    end
                end
                PH_LEN: begin
                    if ((b < LEN_MIN) || (b > LEN_MAX)) begin
                        o_push       = 1'b1;
                        o_cmd.status = ST_BAD_LEN;
                        n_phase      = PH_IDLE;
                        n_count      = '0;
                    end else begin
                        n_plen  = CNT_W'(b - LEN_OVERHEAD);
                        n_count = '0;
                        n_crc   = crc16_byte(CRC_INIT, b);
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_wr_en = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_crc   = crc16_byte(r_crc, b);
                    if (n_count == r_plen) begin
                        n_phase = PH_CRCH;
                    end
                end
                PH_CRCH: begin
                    n_crc_hi = b;
                    n_phase  = PH_CRCL;
                end
                PH_CRCL: begin
                    if ({r_crc_hi, b} != r_crc) begin
                        o_push       = 1'b1;
                        o_cmd.status = ST_BAD_CRC;
                        n_phase      = PH_IDLE;
                        n_count      = '0;
                    end else begin
                        n_phase = PH_END;
                    end
                end
                PH_END: begin
                    o_push  = 1'b1;
                    n_phase = PH_IDLE;
                    n_count = '0;
                    if (b != i_end_byte) begin
                        o_cmd.status = ST_BAD_END;
                    end else begin
                        o_cmd.status = ST_OK;
                        o_cmd.count  = CMD_CNT_W'(r_count);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_count = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_plen   <= '0;
            r_count  <= '0;
            r_crc    <= CRC_INIT;
            r_crc_hi <= '0;
        end else begin
            r_phase  <= n_phase;
            r_plen   <= n_plen;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_crc_hi <= n_crc_hi;
        end
    end

endmodule

[hdl/crcfr_cmd_fifo.sv]
// two-entry queue of frame commands between parser and drain
// depends on crcfr_pkg
module crcfr_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crcfr_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output crcfr_pkg::t_cmd o_cmd,
    output logic            o_empty,
    output logic            o_full
);
    import crcfr_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_level;
    logic       do_push;
    logic       do_pop;

    assign o_empty = (r_level == 2'd0);
    assign o_full  = (r_level == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

[hdl/crcfr_back.sv]
// payload buffer and result drain with an output register
// depends on crcfr_pkg, crcfr_res_if and the assertion macro header
`include "crc16_frame_receiver_macros.svh"

module crcfr_back #(
    parameter int unsigned MAX_PAYLOAD = 20,
    parameter int unsigned ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  crcfr_pkg::t_cmd    i_cmd,
    output logic               o_pop,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  logic [7:0]         i_wr_data,
    output logic               o_busy,
    crcfr_res_if.source        o_res
);
    import crcfr_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_READ = 2'd1;
    localparam logic [1:0] BK_LOAD = 2'd2;

    logic [7:0]       r_mem [MAX_PAYLOAD];
    logic [7:0]       r_rd_data;
    logic             rd_en;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_idx,   n_idx;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_out_status, n_out_status;
    logic [7:0]       r_out_data,   n_out_data;
    logic             r_out_last,   n_out_last;
    logic             out_free;
    logic             at_last;

    assign out_free = !r_out_valid || o_res.ready;
    assign at_last  = ((r_idx + CNT_W'(1)) == r_cnt);
    assign o_busy   = (r_state != BK_IDLE);

    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out_status;
    assign o_res.data_byte = r_out_data;
    assign o_res.last      = r_out_last;

    // payload buffer: one write port from the parser, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        rd_en        = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.status == ST_OK) begin
                        n_cnt   = i_cmd.count[CNT_W-1:0];
                        n_idx   = '0;
                        n_state = BK_READ;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = i_cmd.status;
                        n_out_data   = 8'h00;
                        n_out_last   = 1'b1;
                    end
                end
            end
            BK_READ: begin
                rd_en   = 1'b1;
                n_state = BK_LOAD;
            end
            BK_LOAD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_data   = r_rd_data;
                    n_out_last   = at_last;
                    n_idx        = r_idx + CNT_W'(1);
                    n_state      = at_last ? BK_IDLE : BK_READ;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_cnt        <= n_cnt;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
    end

    `CRCFR_ASSERT_IMPLY(a_wr_only_quiet, i_clk, i_rst_n, i_wr_en,
        (r_state == BK_IDLE) && !i_cmd_valid, "payload write while a drain is pending")
    `CRCFR_ASSERT_IMPLY(a_idx_in_range, i_clk, i_rst_n, r_state != BK_IDLE,
        (r_cnt != '0) && (r_idx < r_cnt), "drain index out of range")
    `CRCFR_ASSERT_IMPLY(a_err_shape, i_clk, i_rst_n, r_out_valid && (r_out_status != ST_OK),
        r_out_last && (r_out_data == 8'h00), "error result not alone or not zero")
    `CRCFR_ASSERT_NEXT(a_last_ends_drain, i_clk, i_rst_n, (r_state == BK_LOAD) && out_free && at_last,
        (r_state == BK_IDLE) && r_out_valid && r_out_last, "drain did not end on last byte")

endmodule

[hdl/crc16_frame_receiver.sv]
// top level: configuration registers, frame parser, command queue, drain
// depends on crcfr_pkg, crcfr_if, crcfr_front, crcfr_cmd_fifo, crcfr_back
//
// channel  | dir | handshake      | payload
// ---------+-----+----------------+----------------------------------
// i_rx     | in  | valid / ready  | rx_byte[7:0]
// o_res    | out | valid / ready  | status[1:0], data_byte[7:0], last
// apb      | in  | psel / penable | paddr[2:0], pwdata, prdata
//
// the parser takes one byte per cycle while i_rx.ready is high; the crc update is one byte per cycle
// a good frame drains each payload byte through a read state and then a load
// state, set by the registered payload buffer read; an error frame puts its one
// result in the output register as it leaves the queue
// payload bytes of the next frame are held off while a command waits in the queue or a good frame drains;
// start, length, crc and end bytes keep flowing unless the queue is full
// i_rst_n is synchronous, active low; output stalls never drop results
module crc16_frame_receiver #(
    parameter int unsigned MAX_PAYLOAD = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    crcfr_byte_if.sink   i_rx,
    crcfr_res_if.source  o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import crcfr_pkg::*;

    localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    // register index from the word address; byte lane bits are ignored
    localparam logic REG_START = 1'b0;
    localparam logic REG_END   = 1'b1;

    logic [7:0]        r_start_val;
    logic [7:0]        r_end_val;
    logic              apb_wr;

    t_flow             flow;
    t_cmd              push_cmd;
    t_cmd              head_cmd;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic              back_busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    // apb: zero wait states, write lands on the access phase
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_val <= START_RST;
            r_end_val   <= END_RST;
        end else begin
            if (apb_wr) begin
                case (paddr[2])
                    REG_START: r_start_val <= pwdata[7:0];
                    REG_END:   r_end_val   <= pwdata[7:0];
                    default:   ;
                endcase
            end
        end
    end

    // read mux, upper bits are zero
    always_comb begin
        case (paddr[2])
            REG_START: prdata = {24'h000000, r_start_val};
            REG_END:   prdata = {24'h000000, r_end_val};
            default:   prdata = 32'h00000000;
        endcase
    end

    // the parser sees queue room and whether the buffer is still draining
    assign flow.full  = q_full;
    assign flow.empty = q_empty;
    assign flow.busy  = back_busy;

    crcfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_byte (r_start_val),
        .i_end_byte   (r_end_val),
        .i_rx         (i_rx),
        .i_flow       (flow),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    // one command per finished frame: good with its byte count, or an error code
    crcfr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // drain: turns each command into its run of results
    crcfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_busy      (back_busy),
        .o_res       (o_res)
    );

endmodule
